FILE: rtl/core/kpd_pkg.sv
// Shared types and constants for the matrix keypad debounce scanner.
// No dependencies; imported by every module of the block.
package kpd_pkg;

   localparam int NUM_ROW_PORTS = 4;
   localparam int NUM_COLS      = 4;

   // result kinds
   localparam logic [1:0] KIND_KEY     = 2'd0;
   localparam logic [1:0] KIND_NONE    = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DOWN_DELAY = 2'd0;
   localparam logic [1:0] CSR_UP_DELAY   = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   typedef logic [NUM_ROW_PORTS-1:0][NUM_COLS-1:0] rows_type;

   typedef struct packed {
      logic       any_down;
      logic       found;
      logic [3:0] key;
   } scan_type;

   typedef struct packed {
      logic [15:0] down_delay;
      logic [15:0] up_delay;
      logic [15:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [3:0]  key;
      logic [15:0] hold;
   } result_type;

endpackage

FILE: rtl/core/matrix_keypad_debounce_scanner_core.sv
// Matrix keypad debounce scanner, top level: request register, configuration
// registers and result register around kpd_scan and kpd_fsm. Depends on kpd_pkg.
//
// Usage: each request is one sampled tick carrying the four active-low column
// nibbles (req_row0_cols .. req_row3_cols), taken at an edge with req_valid high
// and req_stall low. At most one result per request leaves on the rsp_ channel:
// rsp_result_kind (key, no key, timeout), rsp_key_code and rsp_hold_ticks,
// taken at an edge with rsp_valid high and rsp_stall low.
// A result passes the request register and then the result register once its
// request is accepted. Throughput: one request per cycle while req_stall is low;
// the debounce state machine and encoder settle combinationally between those
// two registers.
// While a result waits under rsp_stall the request register holds its tick and
// req_stall rises; an empty request register still takes a new request.
// Configuration: csr_valid/csr_ready with csr_index (0 down delay, 1 up delay,
// 2 timeout) and csr_data; csr_ready is always high, other indexes are ignored.
// Reset (synchronous) returns to idle with down delay 20, up delay 100 and
// timeout disabled, and empties both registers.
module matrix_keypad_debounce_scanner_core #(
   parameter int ROW_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_row0_cols,
   input  logic [3:0]  req_row1_cols,
   input  logic [3:0]  req_row2_cols,
   input  logic [3:0]  req_row3_cols,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [3:0]  rsp_key_code,
   output logic [15:0] rsp_hold_ticks,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import kpd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   rows_type   rows_ff;
   cfg_type    cfg_ff;
   scan_type   scan;
   result_type res;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] kind_ff;
   logic [3:0] key_ff;
   logic [15:0] hold_ff;
   logic       out_busy, step, req_take;

   assign out_busy  = out_valid_ff && rsp_stall;
   assign step      = in_valid_ff && !out_busy;
   assign req_stall = in_valid_ff && out_busy;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = (step && res.valid) || out_busy;

   kpd_scan #(.ROW_COUNT(ROW_COUNT)) u_scan (
      .rows (rows_ff),
      .scan (scan)
   );

   kpd_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .scan  (scan),
      .cfg   (cfg_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         cfg_ff.down_delay <= 16'd20;
         cfg_ff.up_delay   <= 16'd100;
         cfg_ff.timeout    <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DOWN_DELAY: cfg_ff.down_delay <= csr_data;
               CSR_UP_DELAY:   cfg_ff.up_delay   <= csr_data;
               CSR_TIMEOUT:    cfg_ff.timeout    <= csr_data;
               default:        ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         rows_ff <= {req_row3_cols, req_row2_cols, req_row1_cols, req_row0_cols};
      end
      if (step && res.valid) begin
         kind_ff <= res.kind;
         key_ff  <= res.key;
         hold_ff <= res.hold;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_key_code    = key_ff;
   assign rsp_hold_ticks  = hold_ff;

endmodule

FILE: rtl/core/kpd_scan.sv
// Key-down detect and priority encoder over the sampled column nibbles.
// Depends on kpd_pkg.
module kpd_scan #(
   parameter int ROW_COUNT = 4
) (
   input  kpd_pkg::rows_type rows,
   output kpd_pkg::scan_type scan
);
   import kpd_pkg::*;

   localparam int ROWS_USED = (ROW_COUNT < NUM_ROW_PORTS) ? ROW_COUNT : NUM_ROW_PORTS;

   always_comb begin
      scan = '0;
      // walk from the last row down so the lowest row wins;
      // within a row walk from bit 0 up so the highest bit wins
      for (int r = NUM_ROW_PORTS - 1; r >= 0; r--) begin
         if (r < ROWS_USED) begin
            for (int b = 0; b < NUM_COLS; b++) begin
               if (!rows[r][b]) begin
                  scan.any_down = 1'b1;
                  scan.found    = 1'b1;
                  scan.key      = 4'(r * NUM_COLS + (NUM_COLS - 1 - b));
               end
            end
         end
      end
   end

endmodule

FILE: rtl/core/kpd_fsm.sv
// Debounce state machine: press detect, down debounce, release wait, up debounce,
// idle timeout. Consumes one sampled tick per step. Depends on kpd_pkg.
module kpd_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  kpd_pkg::scan_type    scan,
   input  kpd_pkg::cfg_type     cfg,
   output kpd_pkg::result_type  res
);
   import kpd_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DOWN = 2'd1;
   localparam logic [1:0] PH_HELD = 2'd2;
   localparam logic [1:0] PH_UP   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] hold_ff, hold_in;
   logic [15:0] idle_ff, idle_in;
   logic [3:0]  key_ff, key_in;
   logic        found_ff, found_in;

   logic [15:0] delay_inc, hold_inc, idle_inc;

   assign delay_inc = (delay_ff == SAT16) ? delay_ff : delay_ff + 16'd1;
   assign hold_inc  = (hold_ff == SAT16) ? hold_ff : hold_ff + 16'd1;
   assign idle_inc  = (idle_ff == SAT16) ? idle_ff : idle_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      hold_in  = hold_ff;
      idle_in  = idle_ff;
      key_in   = key_ff;
      found_in = found_ff;
      res      = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (scan.any_down) begin
               idle_in  = '0;
               hold_in  = '0;
               delay_in = '0;
               if (cfg.down_delay == '0) begin
                  found_in = scan.found;
                  key_in   = scan.key;
                  phase_in = PH_HELD;
               end else begin
                  found_in = 1'b0;
                  key_in   = '0;
                  phase_in = PH_DOWN;
               end
            end else if (cfg.timeout != '0) begin
               if (idle_inc >= cfg.timeout) begin
                  idle_in   = '0;
                  res.valid = 1'b1;
                  res.kind  = KIND_TIMEOUT;
               end else begin
                  idle_in = idle_inc;
               end
            end
         end
         PH_DOWN: begin
            hold_in  = hold_inc;
            delay_in = delay_inc;
            if (delay_inc >= cfg.down_delay) begin
               found_in = scan.found;
               key_in   = scan.key;
               phase_in = PH_HELD;
            end
         end
         PH_HELD: begin
            hold_in = hold_inc;
            if (!scan.any_down) begin
               delay_in = '0;
               if (cfg.up_delay == '0) begin
                  res.valid = 1'b1;
                  res.kind  = found_ff ? KIND_KEY : KIND_NONE;
                  res.key   = found_ff ? key_ff : 4'd0;
                  res.hold  = hold_inc;
                  phase_in  = PH_IDLE;
                  idle_in   = '0;
               end else begin
                  phase_in = PH_UP;
               end
            end
         end
         PH_UP: begin
            delay_in = delay_inc;
            if (delay_inc >= cfg.up_delay) begin
               res.valid = 1'b1;
               res.kind  = found_ff ? KIND_KEY : KIND_NONE;
               res.key   = found_ff ? key_ff : 4'd0;
               res.hold  = hold_ff;
               phase_in  = PH_IDLE;
               idle_in   = '0;
               delay_in  = '0;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (!step) begin
         res.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= '0;
         hold_ff  <= '0;
         idle_ff  <= '0;
         key_ff   <= '0;
         found_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         hold_ff  <= hold_in;
         idle_ff  <= idle_in;
         key_ff   <= key_in;
         found_ff <= found_in;
      end
   end

endmodule

FILE: rtl/core/kpd_checker.sv
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on kpd_pkg and matrix_keypad_debounce_scanner_core.
module kpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [3:0]  rsp_key_code,
   input logic [15:0] rsp_hold_ticks,
   input logic        csr_ready
);
   import kpd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_key_code) && $stable(rsp_hold_ticks))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_timeout_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_TIMEOUT |-> rsp_key_code == 4'd0
         && rsp_hold_ticks == 16'd0)
      else $error("timeout result carries key or hold time");

   a_nokey_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_NONE |-> rsp_key_code == 4'd0 && csr_ready)
      else $error("no-key result carries a key code");

endmodule

bind matrix_keypad_debounce_scanner_core kpd_checker u_kpd_checker (.*);
